// ===== design/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types, widths and tables for the voxel ray walker.
// ----------------------------------------------------------------------------
package vrt_pkg;

  // configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_VOXEL_EDGE = 1'b0;
  localparam logic [CFG_AW-1:0] REG_END_MARGIN = 1'b1;

  localparam int CFG_W      = 24;
  localparam int IN_TDATA_W = 192;
  localparam int OUT_TDATA_W = 128;
  localparam int CELL_OUT_W = 21;
  localparam int KEY_W      = 63;

  // divider: 67-bit dividend, 34-bit divisor, 33-bit quotient
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 33;
  localparam int DIV_NW = DIV_DW + DIV_QW;
  localparam int DIV_CW = $clog2(DIV_QW + 1);

  // square root: 66-bit radicand, 34-bit root
  localparam int SQ_NW = 66;
  localparam int SQ_RW = 34;
  localparam int SQ_CW = $clog2(SQ_RW + 1);

  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int PM_W  = 64;
  localparam int EM_W  = 57;
  localparam int CW    = 33;   // internal cell index width

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_CHECK,
    ST_AE,
    ST_CELL,
    ST_XP,
    ST_BOUND,
    ST_WALK
  } vrt_state_t;

  // cross products: slot k holds num[pair_a(k)] * ae[pair_b(k)]
  function automatic logic [1:0] pair_a(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0:       r = 2'd1;
      3'd1, 3'd3: r = 2'd2;
      default:    r = (k == 3'd5) ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/vrt_div.sv =====
// ----------------------------------------------------------------------------
// vrt_div
// Restoring divider, one quotient bit per cycle. Dividend must be below
// divisor * 2^DIV_QW.
// ----------------------------------------------------------------------------
module vrt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vrt_pkg::DIV_NW-1:0]  num,
  input  logic [vrt_pkg::DIV_DW-1:0]  den,
  output logic                        done,
  output logic [vrt_pkg::DIV_QW-1:0]  quot,
  output logic [vrt_pkg::DIV_DW-1:0]  rem
);
  import vrt_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_QW-1:0] nlo_r;
  logic [DIV_QW-1:0] q_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign trial = {rem_r, nlo_r[DIV_QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_QW);
        rem_r  <= num[DIV_NW-1:DIV_QW];
        nlo_r  <= num[DIV_QW-1:0];
        den_r  <= den;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        q_r   <= {q_r[DIV_QW-2:0], ge};
        nlo_r <= {nlo_r[DIV_QW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ===== design/vrt_sqrt.sv =====
// ----------------------------------------------------------------------------
// vrt_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module vrt_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vrt_pkg::SQ_NW-1:0]  radicand,
  output logic                       done,
  output logic [vrt_pkg::SQ_RW-1:0]  root
);
  import vrt_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [SQ_CW-1:0]   cnt_r;
  logic [2*SQ_RW-1:0] n_r;
  logic [SQ_RW:0]     rem_r;
  logic [SQ_RW-1:0]   root_r;
  logic [SQ_RW+2:0]   r2;
  logic [SQ_RW+2:0]   trial;
  logic [SQ_RW+2:0]   diff;
  logic               ge;

  assign r2    = {rem_r, n_r[2*SQ_RW-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = r2 >= trial;
  assign diff  = r2 - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SQ_CW'(SQ_RW);
        n_r    <= (2*SQ_RW)'(radicand);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[SQ_RW:0] : r2[SQ_RW:0];
        root_r <= {root_r[SQ_RW-2:0], ge};
        n_r    <= {n_r[2*SQ_RW-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == SQ_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/voxel_ray_traversal.sv =====
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// Walks the voxel grid along one ray and emits every visited voxel.
// ----------------------------------------------------------------------------
// One item is a ray (origin and end point, signed Q15.16). The block takes
// the ray length by square root, trims the end by end_margin, scales the
// direction, locates the start and end voxels, then walks them with a 3D DDA
// (ties go to x, then y). Most of the setup is spent in the shared
// one-bit-per-cycle divider (nine divisions of 33 quotient bits) and the
// 34-bit square root; the walk then emits one voxel per cycle while out_tready
// is high, up to MAX_VOXELS. in_tready is high only while no ray is in work.
module voxel_ray_traversal #(
  parameter int MAX_VOXELS     = 64,
  parameter int KEY_FIELD_BITS = 21
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // cfg port
  input  logic                              cfg_we,
  input  logic [vrt_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [vrt_pkg::CFG_W-1:0]         cfg_wdata,
  // input rays
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // origin_x, origin_y, origin_z, target_x, target_y, target_z (32 b each)
  input  logic [vrt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // visited voxels
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cell_x, cell_y, cell_z (21 b each), cell_key (63 b), 2 b zero pad
  output logic [vrt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  // cut_short
  output logic                              out_tuser
);
  import vrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_VOXELS);
  localparam int STP_W = CNT_W + 1;
  localparam logic [KEY_FIELD_BITS-1:0] KBIAS = {1'b1, {(KEY_FIELD_BITS-1){1'b0}}};

  vrt_state_t state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [3:0] idx_r, idx_nxt;

  logic [CFG_W-1:0] voxel_edge_r, end_margin_r, edge_eff;

  logic signed [31:0] org_r [3];
  logic [32:0]        mag_r [3];
  logic               neg_r [3];
  logic [SQ_NW-1:0]   sum_r;
  logic [SQ_RW-1:0]   dist_r;
  logic [SQ_RW-1:0]   usable_r;
  logic [DIV_QW-1:0]  ae_r [3];
  logic signed [CW-1:0] cell_r [3];
  logic signed [CW-1:0] endc_r [3];
  logic [CFG_W-1:0]   numv_r [3];
  logic [PM_W-1:0]    pm_r [6];
  logic [EM_W-1:0]    em_r [3];
  logic [PROD_W-1:0]  prod_r;
  logic [STP_W-1:0]   steps_r;
  logic [CNT_W-1:0]   count_r;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic               div_start, div_done, sqrt_start, sqrt_done;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den, div_rem;
  logic [DIV_QW-1:0]  div_quot;
  logic [SQ_RW-1:0]   sqrt_root;

  assign edge_eff = (voxel_edge_r == '0) ? CFG_W'(1) : voxel_edge_r;

  // ---------------- input unpack ----------------
  logic signed [31:0] in_o [3], in_t [3];
  logic signed [32:0] in_d [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_o[i] = in_tdata[32*i +: 32];
      in_t[i] = in_tdata[32*(i+3) +: 32];
      in_d[i] = 33'(in_t[i]) - 33'(in_o[i]);
    end
  end

  // ---------------- cell location operand ----------------
  logic signed [33:0] endp [3];
  logic [2:0]         csel;
  logic [1:0]         cj;
  logic signed [33:0] p_sel;
  logic               p_neg;
  logic [33:0]        p_mag;
  logic signed [CW-1:0] cq;
  logic [CFG_W-1:0]   cr;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      endp[i] = 34'(org_r[i]) + (neg_r[i] ? -$signed({1'b0, ae_r[i]})
                                          :  $signed({1'b0, ae_r[i]}));
    end
    csel  = idx_r[2:0];
    cj    = (csel < 3'd3) ? csel[1:0] : 2'(csel - 3'd3);
    p_sel = (csel < 3'd3) ? 34'(org_r[cj]) : endp[cj];
    p_neg = p_sel[33];
    p_mag = p_neg ? 34'(-p_sel) : 34'(p_sel);
    // floor division with non-negative remainder
    if (!p_neg) begin
      cq = $signed(div_quot);
      cr = div_rem[CFG_W-1:0];
    end else if (div_rem == '0) begin
      cq = -$signed(div_quot);
      cr = '0;
    end else begin
      cq = -($signed(div_quot) + CW'(1));
      cr = edge_eff - div_rem[CFG_W-1:0];
    end
  end

  // ---------------- walk decision ----------------
  logic act [3];
  logic xy, xz, yz;
  logic [1:0] ax;
  logic at_end, stop_end, walk_cut, walk_last;

  always_comb begin
    for (int i = 0; i < 3; i++) act[i] = ae_r[i] != '0;
    xy = !act[0] ? !act[1] : (!act[1] || pm_r[0] <= pm_r[2]);
    xz = !act[0] ? !act[2] : (!act[2] || pm_r[1] <= pm_r[4]);
    yz = !act[1] ? !act[2] : (!act[2] || pm_r[3] <= pm_r[5]);
    ax = (xy && xz) ? 2'd0 : (yz ? 2'd1 : 2'd2);
    at_end   = (cell_r[0] == endc_r[0]) && (cell_r[1] == endc_r[1]) &&
               (cell_r[2] == endc_r[2]);
    stop_end = at_end || ({1'b0, count_r} >= steps_r);
    walk_cut = !stop_end && (count_r == CNT_W'(MAX_VOXELS - 1));
    walk_last = stop_end || walk_cut;
  end

  // ---------------- walk bound ----------------
  logic signed [33:0] cdiff [3];
  logic [33:0]        cabs [3];
  logic [35:0]        bound_sum;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cdiff[i] = 34'(endc_r[i]) - 34'(cell_r[i]);
      cabs[i]  = cdiff[i][33] ? 34'(-cdiff[i]) : 34'(cdiff[i]);
    end
    bound_sum = 36'(cabs[0]) + 36'(cabs[1]) + 36'(cabs[2]) + 36'd1;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = ph_r;
    idx_nxt    = idx_r;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    div_num    = DIV_NW'(p_mag);
    div_den    = DIV_DW'(edge_eff);
    mul_a      = MUL_W'(mag_r[idx_r[1:0]]);
    mul_b      = MUL_W'(mag_r[idx_r[1:0]]);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SQ;
          ph_nxt    = 2'd0;
          idx_nxt   = 4'd0;
        end
      end
      ST_SQ: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (idx_r == 4'd2) state_nxt = ST_SQRT;
          else idx_nxt = idx_r + 4'd1;
        end
      end
      ST_SQRT: begin
        if (ph_r == 2'd0) begin
          sqrt_start = 1'b1;
          ph_nxt     = 2'd1;
        end else if (sqrt_done) begin
          state_nxt = ST_CHECK;
          ph_nxt    = 2'd0;
        end
      end
      ST_CHECK: begin
        idx_nxt = 4'd0;
        ph_nxt  = 2'd0;
        if (SQ_RW'(end_margin_r) >= dist_r) state_nxt = ST_IDLE;
        else state_nxt = ST_AE;
      end
      ST_AE: begin
        mul_b   = MUL_W'(usable_r);
        div_num = prod_r[DIV_NW-1:0];
        div_den = dist_r;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          div_start = 1'b1;
          ph_nxt    = 2'd2;
        end else if (div_done) begin
          ph_nxt = 2'd0;
          if (idx_r == 4'd2) begin
            state_nxt = ST_CELL;
            idx_nxt   = 4'd0;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      ST_CELL: begin
        if (ph_r == 2'd0) begin
          div_start = 1'b1;
          ph_nxt    = 2'd1;
        end else if (div_done) begin
          ph_nxt = 2'd0;
          if (idx_r == 4'd5) begin
            state_nxt = ST_XP;
            idx_nxt   = 4'd0;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      ST_XP: begin
        if (idx_r < 4'd6) begin
          mul_a = MUL_W'(numv_r[pair_a(idx_r[2:0])]);
          mul_b = MUL_W'(ae_r[pair_b(idx_r[2:0])]);
        end else begin
          mul_a = MUL_W'(edge_eff);
          mul_b = MUL_W'(ae_r[2'(idx_r - 4'd6)]);
        end
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (idx_r == 4'd8) state_nxt = ST_BOUND;
          else idx_nxt = idx_r + 4'd1;
        end
      end
      ST_BOUND: state_nxt = ST_WALK;
      ST_WALK: begin
        if (out_tready && walk_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ph_r         <= 2'd0;
      idx_r        <= 4'd0;
      voxel_edge_r <= CFG_W'(6554);
      end_margin_r <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_VOXEL_EDGE: voxel_edge_r <= cfg_wdata;
          REG_END_MARGIN: end_margin_r <= cfg_wdata;
        endcase
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            org_r[i] <= in_o[i];
            neg_r[i] <= in_d[i][32];
            mag_r[i] <= in_d[i][32] ? 33'(-in_d[i]) : 33'(in_d[i]);
          end
          sum_r <= '0;
        end
      end
      ST_SQ: begin
        if (ph_r == 2'd1) sum_r <= sum_r + SQ_NW'(prod_r);
      end
      ST_SQRT: begin
        if (ph_r == 2'd1 && sqrt_done) dist_r <= sqrt_root;
      end
      ST_CHECK: usable_r <= dist_r - SQ_RW'(end_margin_r);
      ST_AE: begin
        if (ph_r == 2'd2 && div_done) ae_r[idx_r[1:0]] <= div_quot;
      end
      ST_CELL: begin
        if (ph_r == 2'd1 && div_done) begin
          if (csel < 3'd3) begin
            cell_r[cj] <= cq;
            numv_r[cj] <= neg_r[cj] ? cr : edge_eff - cr;
          end else begin
            endc_r[cj] <= cq;
          end
        end
      end
      ST_XP: begin
        if (ph_r == 2'd1) begin
          if (idx_r < 4'd6) pm_r[idx_r[2:0]] <= prod_r[PM_W-1:0];
          else em_r[2'(idx_r - 4'd6)] <= prod_r[EM_W-1:0];
        end
      end
      ST_BOUND: begin
        steps_r <= (bound_sum >= 36'(MAX_VOXELS)) ? STP_W'(MAX_VOXELS)
                                                  : STP_W'(bound_sum);
        count_r <= '0;
      end
      ST_WALK: begin
        if (out_tready && !walk_last) begin
          count_r <= count_r + 1'b1;
          if (act[ax]) begin
            cell_r[ax] <= neg_r[ax] ? cell_r[ax] - CW'(1) : cell_r[ax] + CW'(1);
            // crossing products for the stepped axis advance by one edge
            for (int k = 0; k < 6; k++) begin
              if (pair_a(3'(k)) == ax)
                pm_r[k] <= pm_r[k] + PM_W'(em_r[pair_b(3'(k))]);
            end
          end
        end
      end
      default: ;
    endcase
  end

  vrt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  vrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // ---------------- output ----------------
  logic [KEY_FIELD_BITS-1:0] kf [3];
  logic [KEY_W-1:0]          cell_key;
  always_comb begin
    for (int i = 0; i < 3; i++) kf[i] = cell_r[i][KEY_FIELD_BITS-1:0] + KBIAS;
    cell_key = {CELL_OUT_W'(kf[0]), CELL_OUT_W'(kf[1]), CELL_OUT_W'(kf[2])};
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_WALK);
  assign out_tdata  = {2'b00, cell_key, cell_r[2][CELL_OUT_W-1:0],
                       cell_r[1][CELL_OUT_W-1:0], cell_r[0][CELL_OUT_W-1:0]};
  assign out_tlast  = walk_last;
  assign out_tuser  = walk_cut;

  // ---------------- assertions ----------------
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a walk is running");

  a_cut_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("cut_short on a non-final item");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("block not idle after final item");

  a_div_not_walk: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !out_tvalid && !in_tready)
    else $error("divider started outside setup");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voxel ray walker.
// ----------------------------------------------------------------------------
// Rays go in with random gaps, voxels come out with random stalls. A
// scoreboard predicts every visited voxel with an exact integer DDA walk and
// compares each output item field by field, including last and cut flags.
// ----------------------------------------------------------------------------

class voxel_scoreboard;
  typedef struct packed {
    logic [20:0] cx, cy, cz;
    logic [62:0] key;
    logic        last, cut;
  } voxel_t;

  voxel_t pending[$];
  logic [23:0] edge_len = 24'd6554;
  logic [23:0] margin = 24'd0;
  int mismatches = 0;
  int voxels_seen = 0;
  int rays_seen = 0;
  int cut_rays = 0;

  function automatic longint cell_floor(longint p, longint e);
    longint q;
    if (p >= 0) q = p / e;
    else q = -((-p + e - 1) / e);
    return q;
  endfunction

  function automatic voxel_t pack_cell(longint c[3]);
    voxel_t v;
    logic [20:0] k[3];
    for (int i = 0; i < 3; i++) k[i] = 21'(c[i] + (1 << 20));
    v.cx = 21'(c[0]);
    v.cy = 21'(c[1]);
    v.cz = 21'(c[2]);
    v.key = {k[0], k[1], k[2]};
    v.last = 1'b0;
    v.cut = 1'b0;
    return v;
  endfunction

  function automatic logic [33:0] isqrt(logic [67:0] n);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  // note one accepted ray and queue every voxel it should visit
  function void note_ray(logic [191:0] d);
    longint e, org[3], vox[3], endc[3], rem, endp, delta;
    logic [63:0] mag[3], ae[3], num[3];
    logic [67:0] sum;
    logic [127:0] prod;
    logic [33:0] ray_len, usable;
    logic neg[3], act[3], xy, xz, yz, cut;
    longint maxsteps, count;
    int n, ax;
    voxel_t v;
    e = (edge_len == 0) ? 1 : longint'(edge_len);
    sum = '0;
    rays_seen++;
    for (int i = 0; i < 3; i++) begin
      org[i] = longint'($signed(d[32*i +: 32]));
      delta = longint'($signed(d[32*(i+3) +: 32])) - org[i];
      neg[i] = delta < 0;
      mag[i] = neg[i] ? -delta : delta;
      sum += 68'(mag[i]) * 68'(mag[i]);
    end
    ray_len = isqrt(sum);
    if (ray_len == 0 || {10'd0, margin} >= ray_len) return;
    usable = ray_len - margin;
    maxsteps = 1;
    for (int i = 0; i < 3; i++) begin
      prod = 128'(mag[i]) * 128'(usable);
      ae[i] = 64'(prod / ray_len);
      endp = org[i] + (neg[i] ? -longint'(ae[i]) : longint'(ae[i]));
      vox[i] = cell_floor(org[i], e);
      rem = org[i] - vox[i] * e;
      endc[i] = cell_floor(endp, e);
      maxsteps += (endc[i] >= vox[i]) ? endc[i] - vox[i] : vox[i] - endc[i];
      act[i] = ae[i] != 0;
      num[i] = neg[i] ? rem : e - rem;
    end
    v = pack_cell(vox);
    n = 1;
    cut = 1'b0;
    count = 0;
    while (count < maxsteps &&
           (vox[0] != endc[0] || vox[1] != endc[1] || vox[2] != endc[2])) begin
      if (n == 64) begin
        cut = 1'b1;
        break;
      end
      pending.insert(pending.size(), v);
      xy = !act[0] ? !act[1] : (!act[1] || num[0] * ae[1] <= num[1] * ae[0]);
      xz = !act[0] ? !act[2] : (!act[2] || num[0] * ae[2] <= num[2] * ae[0]);
      yz = !act[1] ? !act[2] : (!act[2] || num[1] * ae[2] <= num[2] * ae[1]);
      ax = (xy && xz) ? 0 : (yz ? 1 : 2);
      if (act[ax]) begin
        vox[ax] += neg[ax] ? -1 : 1;
        num[ax] += e;
      end
      v = pack_cell(vox);
      n++;
      count++;
    end
    v.last = 1'b1;
    v.cut = cut;
    if (cut) cut_rays++;
    pending.insert(pending.size(), v);
  endfunction

  function void check_voxel(logic [127:0] d, logic tl, logic tu);
    voxel_t got, want;
    got = {d[20:0], d[41:21], d[62:42], d[125:63], tl, tu};
    voxels_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected voxel %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("voxel mismatch: exp x=%h y=%h z=%h key=%h l=%b c=%b",
                 want.cx, want.cy, want.cz, want.key, want.last, want.cut);
        $display("                got x=%h y=%h z=%h key=%h l=%b c=%b",
                 got.cx, got.cy, got.cz, got.key, got.last, got.cut);
      end
    end
  endfunction
endclass

module tb_top;
  import vrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  int send_idle_pct = 38;
  int recv_idle_pct = 57;
  longint cycles = 0;
  voxel_scoreboard sb = new();

  voxel_ray_traversal dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall, check on handshake
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_voxel(out_tdata, out_tlast, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_VOXEL_EDGE) sb.edge_len = val;
    else sb.margin = val;
  endtask

  task automatic send_ray(logic [31:0] ox, oy, oz, tx, ty, tz);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {tz, ty, tx, oz, oy, ox};
    do @(posedge clk); while (!in_tready);
    sb.note_ray({tz, ty, tx, oz, oy, ox});
    in_tvalid <= 1'b0;
  endtask

  // wait for all voxels, then for any trailing setup of a ray with no output
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // short rays around a random origin, some long and some wild
  task automatic random_ray(int span);
    logic [31:0] o[3], t[3];
    int r;
    for (int i = 0; i < 3; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        o[i] = $urandom();
        t[i] = $urandom();
      end else begin
        o[i] = $urandom_range(0, 1 << 22) - (1 << 21);
        t[i] = (r < 20) ? o[i] : o[i] + $urandom_range(0, 2 * span) - span;
      end
    end
    send_ray(o[0], o[1], o[2], t[0], t[1], t[2]);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rays, first at reset settings, then at other edge and margin settings
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_ray(0, 0, 0, 6554 * 3, 0, 0);
    send_ray(0, 0, 0, 6554 * 2, 6554 * 2, 6554 * 2);
    send_ray(-100, -100, -100, -30000, 20000, -5);
    send_ray(5, 5, 5, 5, 5, 200000);
    drain();
    write_reg(REG_END_MARGIN, 24'd6554);
    send_ray(0, 0, 0, 6554 * 4, 0, 0);
    send_ray(0, 0, 0, 100, 0, 0);
    drain();
    write_reg(REG_VOXEL_EDGE, 24'd0);
    write_reg(REG_END_MARGIN, 24'd0);
    send_ray(0, 0, 0, 40, -30, 10);
    send_ray(-7, 3, 0, -7, 3, 1);
    drain();
    write_reg(REG_VOXEL_EDGE, 24'hff_ffff);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(-1, 0, 1, 1, -1, 0);
    drain();
    write_reg(REG_VOXEL_EDGE, 24'd1);
    write_reg(REG_END_MARGIN, 24'hff_ffff);
    send_ray(0, 0, 0, 32'h0100_0000, 0, 0);
    send_ray(0, 0, 0, 32'h0200_0000, 0, 0);
    drain();
    write_reg(REG_END_MARGIN, 24'd0);
    send_ray(-3, 9, 2, 60, -20, 11);
    drain();

    // random phases: settings change between phases
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 57;
        recv_idle_pct = 38;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_VOXEL_EDGE, (ph % 2) ? CFG_W'($urandom_range(1, 24'hff_ffff)) :
                CFG_W'($urandom_range(256, 20000)));
      write_reg(REG_END_MARGIN, (ph == 3) ? CFG_W'($urandom_range(0, 24'hff_ffff)) :
                CFG_W'($urandom_range(0, 3000)));
      for (int k = 0; k < 65; k++) random_ray((ph % 2) ? 2000000 : 200000);
      drain();
    end

    $display("rays %0d, voxels %0d, cut walks %0d, mismatches %0d",
             sb.rays_seen, sb.voxels_seen, sb.cut_rays, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/vrt_pkg.sv
design/vrt_div.sv
design/vrt_sqrt.sv
design/voxel_ray_traversal.sv
test/tb_top.sv
